// ===== sv/assert_macros.svh =====
// Assertion helpers used by the datapath RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define RMH_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rmh: invariant violated");

// consequent holds in the same cycle as the antecedent
`define RMH_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmh: implication violated");

`endif

// ===== sv/rmh_pkg.sv =====
package rmh_pkg;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_TAKE       = 4'd1,
        OP_MOVE       = 4'd2,
        OP_PUSH_INIT  = 4'd3,
        OP_RD_PARENT  = 4'd4,
        OP_PUSH_UP    = 4'd5,
        OP_HOLE_WRITE = 4'd6,
        OP_POP_INIT   = 4'd7,
        OP_POP_TOP    = 4'd8,
        OP_POP_LAST   = 4'd9,
        OP_RD_L       = 4'd10,
        OP_RD_R       = 4'd11,
        OP_DOWN_L     = 4'd12,
        OP_DOWN_R     = 4'd13,
        OP_RD_TOPS    = 4'd14,
        OP_MED        = 4'd15
    } rmh_op_t;

    typedef struct packed {
        rmh_op_t op;
        logic    sel;   // 0: lower (max) heap, 1: upper (min) heap
        logic    drop;
    } rmh_cmd_t;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic up;
        logic l_in;
        logic go_l;
        logic go_r;
        logic tops_gt;
        logic usize_nz;
        logic l_heavy;
        logic u_heavy;
    } rmh_stat_t;

endpackage

// ===== sv/rmh_if.sv =====
interface rmh_in_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rmh_out_if #(parameter int W = 32, parameter int CW = 11) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] median;
    logic [CW-1:0]       element_count;
    logic                full_drop;

    modport source (output valid, output median, output element_count, output full_drop,
                    input ready);
    modport sink   (input valid, input median, input element_count, input full_drop,
                    output ready);
endinterface

// ===== sv/rmh_ram.sv =====
module rmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 514
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/rmh_datapath.sv =====
`include "assert_macros.svh"

module rmh_datapath
    import rmh_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int W        = 32,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rmh_cmd_t            cmd,
    output rmh_stat_t           stat,
    input  logic signed [W-1:0] in_value,
    output logic signed [W-1:0] median,
    output logic [CW-1:0]       element_count,
    output logic                full_drop
);
    localparam int HD = CAPACITY / 2 + 2;
    localparam int AW = $clog2(HD);
    localparam int SW = $clog2(HD + 1);

    logic [SW-1:0] lsize_reg, usize_reg, cur_size;
    logic [AW-1:0] idx_reg, parent, l_addr, r_addr, raddr, waddr;
    logic [SW:0]   l_ext, r_ext;
    logic signed [W-1:0] val_reg, top_reg, lch_reg, med_reg;
    logic signed [W-1:0] l_rdata, u_rdata, rd, wdata;
    logic [CW-1:0] cnt_reg, tot;
    logic          drop_reg, wr;

    function automatic logic above(input logic signed [W-1:0] a,
                                   input logic signed [W-1:0] b,
                                   input logic is_min);
        return is_min ? (a < b) : (a > b);
    endfunction

    assign cur_size = cmd.sel ? usize_reg : lsize_reg;
    assign rd       = cmd.sel ? u_rdata : l_rdata;
    assign parent   = (idx_reg - AW'(1)) >> 1;
    assign l_ext    = (SW + 1)'({idx_reg, 1'b1});
    assign r_ext    = l_ext + (SW + 1)'(1);
    assign l_addr   = l_ext[AW-1:0];
    assign r_addr   = r_ext[AW-1:0];
    assign tot      = CW'(lsize_reg) + CW'(usize_reg);

    always_comb
    begin
        case (cmd.op)
            OP_RD_PARENT: raddr = parent;
            OP_POP_TOP:   raddr = cur_size[AW-1:0];
            OP_RD_L:      raddr = l_addr;
            OP_RD_R:      raddr = r_addr;
            default:      raddr = '0;
        endcase
    end

    always_comb
    begin
        wr    = 1'b1;
        waddr = idx_reg;
        case (cmd.op)
            OP_HOLE_WRITE: wdata = val_reg;
            OP_PUSH_UP:    wdata = rd;
            OP_DOWN_R:     wdata = rd;
            OP_DOWN_L:     wdata = lch_reg;
            default:
            begin
                wr    = 1'b0;
                wdata = val_reg;
            end
        endcase
    end

    rmh_ram #(.WIDTH(W), .DEPTH(HD)) u_lower_ram (
        .clk   (clk),
        .we    (wr && !cmd.sel),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (l_rdata)
    );

    rmh_ram #(.WIDTH(W), .DEPTH(HD)) u_upper_ram (
        .clk   (clk),
        .we    (wr && cmd.sel),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (u_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsize_reg <= '0;
            usize_reg <= '0;
        end
        else if (cmd.op == OP_PUSH_INIT)
        begin
            if (cmd.sel)
                usize_reg <= usize_reg + SW'(1);
            else
                lsize_reg <= lsize_reg + SW'(1);
        end
        else if (cmd.op == OP_POP_INIT)
        begin
            if (cmd.sel)
                usize_reg <= usize_reg - SW'(1);
            else
                lsize_reg <= lsize_reg - SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_TAKE:      val_reg <= in_value;
            OP_MOVE:      val_reg <= top_reg;
            OP_PUSH_INIT: idx_reg <= cur_size[AW-1:0];
            OP_PUSH_UP:   idx_reg <= parent;
            OP_POP_TOP:   top_reg <= rd;
            OP_POP_LAST:
            begin
                val_reg <= rd;
                idx_reg <= '0;
            end
            OP_RD_R:      lch_reg <= rd;
            OP_DOWN_L:    idx_reg <= l_addr;
            OP_DOWN_R:    idx_reg <= r_addr;
            OP_MED:
            begin
                med_reg  <= (lsize_reg != '0) ? l_rdata : '0;
                cnt_reg  <= tot;
                drop_reg <= cmd.drop;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.full     = tot >= CW'(CAPACITY);
        stat.idx_zero = idx_reg == '0;
        stat.up       = above(val_reg, rd, cmd.sel);
        stat.l_in     = l_ext < {1'b0, cur_size};
        stat.go_l     = above(lch_reg, val_reg, cmd.sel);
        stat.go_r     = (r_ext < {1'b0, cur_size})
                        && above(rd, stat.go_l ? lch_reg : val_reg, cmd.sel);
        stat.tops_gt  = l_rdata > u_rdata;
        stat.usize_nz = usize_reg != '0;
        stat.l_heavy  = (SW + 1)'(lsize_reg) > (SW + 1)'(usize_reg) + (SW + 1)'(1);
        stat.u_heavy  = lsize_reg < usize_reg;
    end

    assign median        = med_reg;
    assign element_count = cnt_reg;
    assign full_drop     = drop_reg;

    `RMH_ASSERT_ALWAYS(a_skew, clk, rst_n,
        (SW + 1)'(lsize_reg) <= (SW + 1)'(usize_reg) + (SW + 1)'(2))
    `RMH_ASSERT_ALWAYS(a_cap, clk, rst_n, tot <= CW'(CAPACITY))
    `RMH_ASSERT_IMPLIES(a_bal_out, clk, rst_n, cmd.op == OP_MED,
        lsize_reg == usize_reg || (SW + 1)'(lsize_reg) == (SW + 1)'(usize_reg) + (SW + 1)'(1))
endmodule

// ===== sv/rmh_ctrl.sv =====
module rmh_ctrl
    import rmh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  rmh_stat_t stat,
    output rmh_cmd_t  cmd
);
    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_PINIT    = 16'b0000_0000_0000_0010,
        S_PUSH     = 16'b0000_0000_0000_0100,
        S_PSTEP    = 16'b0000_0000_0000_1000,
        S_CMP_RD   = 16'b0000_0000_0001_0000,
        S_CMP      = 16'b0000_0000_0010_0000,
        S_BAL      = 16'b0000_0000_0100_0000,
        S_POP_INIT = 16'b0000_0000_1000_0000,
        S_POP_TOP  = 16'b0000_0001_0000_0000,
        S_POP_LAST = 16'b0000_0010_0000_0000,
        S_POP_L    = 16'b0000_0100_0000_0000,
        S_POP_RDR  = 16'b0000_1000_0000_0000,
        S_POP_CHK  = 16'b0001_0000_0000_0000,
        S_MOVE     = 16'b0010_0000_0000_0000,
        S_MED_RD   = 16'b0100_0000_0000_0000,
        S_MED      = 16'b1000_0000_0000_0000
    } rmh_state_t;

    rmh_state_t state_reg, state_next;
    logic sel_reg, sel_next, bal_reg, bal_next, drop_reg, drop_next;
    logic out_valid_reg, out_valid_next;
    rmh_op_t op;
    rmh_state_t push_done;

    assign push_done = bal_reg ? S_BAL : S_CMP_RD;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        bal_next   = bal_reg;
        drop_next  = drop_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op        = OP_TAKE;
                    sel_next  = 1'b0;
                    bal_next  = 1'b0;
                    drop_next = stat.full;
                    state_next = stat.full ? S_MED_RD : S_PINIT;
                end
            end
            S_PINIT:
            begin
                op         = OP_PUSH_INIT;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (stat.idx_zero)
                begin
                    op         = OP_HOLE_WRITE;
                    state_next = push_done;
                end
                else
                begin
                    op         = OP_RD_PARENT;
                    state_next = S_PSTEP;
                end
            end
            S_PSTEP:
            begin
                if (stat.up)
                begin
                    op         = OP_PUSH_UP;
                    state_next = S_PUSH;
                end
                else
                begin
                    op         = OP_HOLE_WRITE;
                    state_next = push_done;
                end
            end
            S_CMP_RD:
            begin
                op         = OP_RD_TOPS;
                bal_next   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (stat.usize_nz && stat.tops_gt)
                begin
                    sel_next   = 1'b0;
                    state_next = S_POP_INIT;
                end
                else
                begin
                    state_next = S_BAL;
                end
            end
            S_BAL:
            begin
                if (stat.l_heavy)
                begin
                    sel_next   = 1'b0;
                    state_next = S_POP_INIT;
                end
                else if (stat.u_heavy)
                begin
                    sel_next   = 1'b1;
                    state_next = S_POP_INIT;
                end
                else
                begin
                    state_next = S_MED_RD;
                end
            end
            S_POP_INIT:
            begin
                op         = OP_POP_INIT;
                state_next = S_POP_TOP;
            end
            S_POP_TOP:
            begin
                op         = OP_POP_TOP;
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                op         = OP_POP_LAST;
                state_next = S_POP_L;
            end
            S_POP_L:
            begin
                if (stat.l_in)
                begin
                    op         = OP_RD_L;
                    state_next = S_POP_RDR;
                end
                else
                begin
                    op         = OP_HOLE_WRITE;
                    state_next = S_MOVE;
                end
            end
            S_POP_RDR:
            begin
                op         = OP_RD_R;
                state_next = S_POP_CHK;
            end
            S_POP_CHK:
            begin
                if (stat.go_r)
                begin
                    op         = OP_DOWN_R;
                    state_next = S_POP_L;
                end
                else if (stat.go_l)
                begin
                    op         = OP_DOWN_L;
                    state_next = S_POP_L;
                end
                else
                begin
                    op         = OP_HOLE_WRITE;
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // popped top goes into the other heap
                op         = OP_MOVE;
                sel_next   = !sel_reg;
                state_next = S_PINIT;
            end
            S_MED_RD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op         = OP_RD_TOPS;
                    state_next = S_MED;
                end
            end
            S_MED:
            begin
                op         = OP_MED;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == S_MED)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            bal_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            bal_reg       <= bal_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;
    assign cmd.sel   = sel_reg;
    assign cmd.drop  = drop_reg;
endmodule

// ===== sv/running_median_two_heaps_unit.sv =====
// Running median over a stream of signed values, held as a max-heap of the
// lower half and a min-heap of the upper half, each in its own RAM. Every
// request inserts one value and returns the lower median, the element count
// and a flag set when the store was already full (value dropped). One request
// is worked at a time; the next is taken while the previous result waits.
// An insert is a push that climbs the heap level by level, followed by up
// to two moves between the heaps, each a pop that sifts down level by level
// and a push of the popped top into the other heap. The time taken is set by
// the walk through the heap RAMs, with registered reads at each level. A
// dropped request inserts nothing and only reads out the median.
module running_median_two_heaps_unit
    import rmh_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input logic   clk,
    input logic   rst_n,
    rmh_in_if.sink    sample,
    rmh_out_if.source result
);
    localparam int CW = $clog2(CAPACITY + 1);

    rmh_cmd_t  cmd;
    rmh_stat_t stat;

    rmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rmh_datapath #(.CAPACITY(CAPACITY), .W(VALUE_BITS), .CW(CW)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_value      (sample.value),
        .median        (result.median),
        .element_count (result.element_count),
        .full_drop     (result.full_drop)
    );
endmodule
